### rtl/rkq_pkg.sv
// Shared constants, codes and types of the range k-th smallest query block.
`default_nettype none

package rkq_pkg;

    localparam int DEFAULT_MAX_ELEMENTS = 1024;
    localparam int DEFAULT_VALUE_BITS   = 32;

    // Fixed widths of the request and result fields.
    localparam int FIELD_VALUE_BITS = 32;
    localparam int POSITION_BITS    = 10;
    localparam int RANK_BITS        = 11;
    localparam int COUNT_BITS       = 11;

    // Width of the value slice that one compare cell handles.
    localparam int SLICE_BITS = 8;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_EMIT
    } rkq_state_t;

    // Compare status handed from one cell to the next.
    typedef struct packed {
        logic valid;
        logic lt;
        logic eq;
    } rkq_link_t;

endpackage

`default_nettype wire

### rtl/rkq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rkq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/rkq_cell.sv
// One compare cell: weighs one slice of an element against its slice of the probe.
`default_nettype none

module rkq_cell #(
    parameter int WORD_BITS  = 32,
    parameter int SLICE_LSB  = 0
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire logic [rkq_pkg::SLICE_BITS-1:0]    probe_slice,
    input  wire rkq_pkg::rkq_link_t                link_in,
    input  wire logic [WORD_BITS-1:0]              elem_in,
    output rkq_pkg::rkq_link_t                     link_out,
    output logic      [WORD_BITS-1:0]              elem_out
);

    logic [rkq_pkg::SLICE_BITS-1:0] probe_reg;
    logic [rkq_pkg::SLICE_BITS-1:0] elem_slice;
    rkq_pkg::rkq_link_t             link_reg;
    rkq_pkg::rkq_link_t             link_next;
    logic [WORD_BITS-1:0]           elem_reg;

    assign elem_slice = elem_in[SLICE_LSB +: rkq_pkg::SLICE_BITS];

    // The verdict is settled by the most significant slice that differs.
    always_comb
    begin
        link_next.valid = link_in.valid;
        link_next.lt    = link_in.lt | (link_in.eq & (elem_slice < probe_reg));
        link_next.eq    = link_in.eq & (elem_slice == probe_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_in;
        if (load)
        begin
            probe_reg <= probe_slice;
        end
    end

    assign link_out = link_reg;
    assign elem_out = elem_reg;

endmodule

`default_nettype wire

### rtl/range_kth_smallest_query.sv
// Range k-th smallest query block: element store, search sequencer and compare chain.
//
// Requests arrive on req_valid/req_stall. A load request (command 0) writes
// element_value at position; a position at or beyond MAX_ELEMENTS is
// dropped. A query request (command 1) returns one result on rsp_valid/
// rsp_stall: the rank_wanted-th smallest value in range_first..range_last,
// with range_last clipped to the element count. found is low when rank_wanted
// is zero or the range holds fewer elements than asked, and kth_value is then zero.
// The answer is decided one value bit per pass, top bit first. Each pass
// reads the range from the RAM one element per cycle into a chain of compare
// cells, each cell judging one byte, and counts elements at or below the probe.
// A pass runs the probe, scan, drain and decide steps in that order; a query
// that cannot be answered goes straight to the emit step. Requests are taken
// one at a time.
// The result register holds the answer while the receiver stalls; the block
// still takes loads then, and a finished query waits for the register.
// Reset clears the element count and the control state; the RAM is not
// cleared, and only written positions may be queried. The user must write
// element_count through cfg_valid/cfg_ready while the block idles; not enforced.
`default_nettype none

module range_kth_smallest_query #(
    parameter int MAX_ELEMENTS = rkq_pkg::DEFAULT_MAX_ELEMENTS,
    parameter int VALUE_BITS   = rkq_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       cfg_valid,
    output logic                                            cfg_ready,
    input  wire logic        [rkq_pkg::COUNT_BITS-1:0]      cfg_element_count,
    input  wire logic                                       req_valid,
    output logic                                            req_stall,
    input  wire logic                                       command,
    input  wire logic        [rkq_pkg::POSITION_BITS-1:0]   position,
    input  wire logic signed [rkq_pkg::FIELD_VALUE_BITS-1:0] element_value,
    input  wire logic        [rkq_pkg::POSITION_BITS-1:0]   range_first,
    input  wire logic        [rkq_pkg::POSITION_BITS-1:0]   range_last,
    input  wire logic        [rkq_pkg::RANK_BITS-1:0]       rank_wanted,
    output logic                                            rsp_valid,
    input  wire logic                                       rsp_stall,
    output logic signed      [rkq_pkg::FIELD_VALUE_BITS-1:0] kth_value,
    output logic                                            found
);

    localparam int AW  = $clog2(MAX_ELEMENTS);
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int QW  = (CW > rkq_pkg::COUNT_BITS) ? CW : rkq_pkg::COUNT_BITS;
    localparam int SB  = rkq_pkg::SLICE_BITS;
    localparam int NC  = (VALUE_BITS + SB - 1) / SB;
    localparam int PW  = NC * SB;
    localparam int DCW = $clog2(NC + 1);
    localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, (VALUE_BITS-1)'(0)};

    rkq_pkg::rkq_state_t state_reg, state_next;

    logic [rkq_pkg::COUNT_BITS-1:0] element_count_reg;

    logic [AW-1:0]         first_reg, last_reg, addr_reg;
    logic [QW-1:0]         rank_reg, total_reg, count_reg;
    logic                  possible_reg;
    logic                  rd_valid_reg;
    logic [VALUE_BITS-1:0] ans_reg, bit_reg;
    logic [DCW-1:0]        drain_reg;
    logic                  out_valid_reg;
    logic signed [rkq_pkg::FIELD_VALUE_BITS-1:0] kth_reg;
    logic                  found_reg;

    logic req_accept, is_query, pos_ok;
    logic ram_we, ram_re, cells_load, emit_fire;

    logic [QW-1:0] n_q, first_q, last_q, total_q, rank_q;
    logic          possible;

    logic signed [VALUE_BITS-1:0] load_wrapped;
    logic signed [VALUE_BITS-1:0] ans_signed;
    logic [VALUE_BITS-1:0]        ram_wdata, ram_rdata, probe;
    logic [PW-1:0]                probe_pad;
    logic [QW-1:0]                count_step;

    rkq_pkg::rkq_link_t link_chain [NC+1];
    logic [PW-1:0]      elem_chain [NC+1];

    assign cfg_ready  = 1'b1;
    assign req_accept = req_valid & ~req_stall;
    assign is_query   = (command == rkq_pkg::CMD_QUERY);
    assign pos_ok     = (QW'(position) < QW'(MAX_ELEMENTS));

    // Clip the query range to the elements in use and decide if it can answer.
    always_comb
    begin
        logic [QW-1:0] cnt_q;
        logic [QW-1:0] max_q;
        logic          nonempty;
        cnt_q   = QW'(element_count_reg);
        max_q   = QW'(MAX_ELEMENTS);
        n_q     = (cnt_q > max_q) ? max_q : cnt_q;
        first_q = QW'(range_first);
        last_q  = QW'(range_last);
        if ((n_q != '0) && (last_q > n_q - QW'(1)))
        begin
            last_q = n_q - QW'(1);
        end
        nonempty = (n_q != '0) && (first_q <= last_q);
        total_q  = nonempty ? (last_q - first_q + QW'(1)) : '0;
        rank_q   = QW'(rank_wanted);
        possible = (rank_q != '0) && (total_q >= rank_q);
    end

    // Values are held in offset binary so that an unsigned compare orders them.
    assign load_wrapped = VALUE_BITS'(element_value);
    assign ram_wdata    = load_wrapped ^ SIGN_BIT;
    assign ans_signed   = ans_reg ^ SIGN_BIT;

    assign probe     = ans_reg | (bit_reg - VALUE_BITS'(1));
    assign probe_pad = PW'(probe);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rkq_pkg::ST_IDLE:
            begin
                if (req_accept && is_query)
                begin
                    state_next = possible ? rkq_pkg::ST_PROBE : rkq_pkg::ST_EMIT;
                end
            end
            rkq_pkg::ST_PROBE:
            begin
                state_next = rkq_pkg::ST_SCAN;
            end
            rkq_pkg::ST_SCAN:
            begin
                if (addr_reg == last_reg)
                begin
                    state_next = rkq_pkg::ST_DRAIN;
                end
            end
            rkq_pkg::ST_DRAIN:
            begin
                if (drain_reg == DCW'(NC))
                begin
                    state_next = rkq_pkg::ST_DECIDE;
                end
            end
            rkq_pkg::ST_DECIDE:
            begin
                state_next = bit_reg[0] ? rkq_pkg::ST_EMIT : rkq_pkg::ST_PROBE;
            end
            rkq_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    state_next = rkq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rkq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall  = (state_reg != rkq_pkg::ST_IDLE);
        ram_re     = (state_reg == rkq_pkg::ST_SCAN);
        cells_load = (state_reg == rkq_pkg::ST_PROBE);
        emit_fire  = (state_reg == rkq_pkg::ST_EMIT) && (!out_valid_reg || !rsp_stall);
        ram_we     = req_accept && !is_query && pos_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= rkq_pkg::ST_IDLE;
            element_count_reg <= '0;
            addr_reg          <= '0;
            rd_valid_reg      <= 1'b0;
            count_reg         <= '0;
            drain_reg         <= '0;
            ans_reg           <= '0;
            bit_reg           <= SIGN_BIT;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= ram_re;
            if (cfg_valid && cfg_ready)
            begin
                element_count_reg <= cfg_element_count;
            end
            if (req_accept && is_query)
            begin
                ans_reg <= '0;
                bit_reg <= SIGN_BIT;
            end
            if (state_reg == rkq_pkg::ST_PROBE)
            begin
                addr_reg  <= first_reg;
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_reg + count_step;
            end
            if (state_reg == rkq_pkg::ST_SCAN)
            begin
                addr_reg  <= addr_reg + AW'(1);
                drain_reg <= '0;
            end
            if (state_reg == rkq_pkg::ST_DRAIN)
            begin
                drain_reg <= drain_reg + DCW'(1);
            end
            if (state_reg == rkq_pkg::ST_DECIDE)
            begin
                // Too few elements at or below the probe: the answer has this bit set.
                if (count_reg < rank_reg)
                begin
                    ans_reg <= ans_reg | bit_reg;
                end
                if (!bit_reg[0])
                begin
                    bit_reg <= bit_reg >> 1;
                end
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept && is_query)
        begin
            first_reg    <= AW'(first_q);
            last_reg     <= AW'(last_q);
            rank_reg     <= rank_q;
            total_reg    <= total_q;
            possible_reg <= possible;
        end
        if (emit_fire)
        begin
            kth_reg   <= possible_reg ? rkq_pkg::FIELD_VALUE_BITS'(ans_signed) : '0;
            found_reg <= possible_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign kth_value = kth_reg;
    assign found     = found_reg;

    rkq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(position)),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign link_chain[0] = '{valid: rd_valid_reg, lt: 1'b0, eq: 1'b1};
    assign elem_chain[0] = PW'(ram_rdata);

    // Cell 0 judges the most significant slice; the element moves one cell a cycle.
    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        rkq_cell #(
            .WORD_BITS (PW),
            .SLICE_LSB ((NC - 1 - i) * SB)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .load        (cells_load),
            .probe_slice (probe_pad[(NC - 1 - i) * SB +: SB]),
            .link_in     (link_chain[i]),
            .elem_in     (elem_chain[i]),
            .link_out    (link_chain[i+1]),
            .elem_out    (elem_chain[i+1])
        );
    end

    assign count_step = QW'(link_chain[NC].valid & (link_chain[NC].lt | link_chain[NC].eq));

    a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(bit_reg))
        else $error("search bit mask is not one-hot");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rkq_pkg::ST_SCAN) |-> (addr_reg >= first_reg) && (addr_reg <= last_reg))
        else $error("scan address left the query range");

    a_decide_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rkq_pkg::ST_DECIDE) |->
            !link_chain[NC].valid && !rd_valid_reg && (count_reg <= total_reg))
        else $error("decision taken before the compare chain drained");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == rkq_pkg::ST_EMIT))
        else $error("result appeared outside the emit step");

endmodule

`default_nettype wire
